### hw/rtl/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// No dependencies; imported by sfs_mod_unit and sprite_frame_sequencer_core.
`default_nettype none

package sfs_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF = 256;
    localparam int FRAME_BITS_DEF = 16;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int DT_W     = 20;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 16;
    localparam int POS_W    = 8;
    localparam int RATE_W   = 16;
    localparam int FCNT_W   = 9;
    localparam int REP_W    = 17;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 17;

    // Phase has 16 fraction bits; rate*dt carries 28, the low 12 are dropped
    localparam int PHASE_FRAC = 16;
    localparam int PROD_W     = RATE_W + DT_W;
    localparam int PROD_SHIFT = 12;
    localparam int INC_W      = PROD_W - PROD_SHIFT;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_FRAME_RATE   = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_FRAME_COUNT  = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_REPEAT_COUNT = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_YOYO_ENABLE  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0] FRAME_RATE_RST  = 16'd15360;
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = 9'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DT_W-1:0]   delta_time;
        logic [IDX_W-1:0]  entry_index;
        logic [VAL_W-1:0]  entry_value;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] frame_value;
        logic [POS_W-1:0] position;
        logic             reversed;
        logic             done_res;
    } result_t;

    // Status of the serial modulo unit
    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

endpackage

`default_nettype wire

### hw/rtl/sprite_frame_sequencer_core.sv
// Sprite frame sequencer top level: frame table memory, playback state, FSM.
// Depends on sfs_pkg and sfs_mod_unit.
`default_nettype none

// One item is taken at a time and answered with exactly one result. Load,
// start and unknown items, and ticks after playback has finished, go from
// execution to the table read and the response. A tick that does not end a
// pass first takes the registered multiply, then the phase add. A tick that
// wraps with a repeat or yoyo pass left also computes the serial remainder
// by the frame count, one bit per cycle. The next item can be taken in the
// same cycle as the result is raised. The frame table is a one-port
// synchronous memory with unknown contents after reset; entries must be
// loaded before they are shown. Results sit in an output register, so the
// next item is taken while a result still waits. Configuration writes are
// accepted every cycle and must only be issued while the block is idle.
module sprite_frame_sequencer_core
    import sfs_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire item_t               item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output result_t                  result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [CFG_D_W-1:0]  cfg_data
);

    localparam int AW      = $clog2(MAX_FRAMES);
    localparam int PW_A    = AW + PHASE_FRAC;
    localparam int PHASE_W = ((PW_A > INC_W) ? PW_A : INC_W) + 1;
    localparam int Q_W     = PHASE_W - PHASE_FRAC;

    // FSM codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    item_t               item_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    logic [RATE_W-1:0]   frame_rate_reg;
    logic [FCNT_W-1:0]   frame_count_reg;
    logic [REP_W-1:0]    repeat_count_reg;
    logic                yoyo_enable_reg;

    logic [PHASE_W-1:0]  phase_reg;
    logic [REP_W-1:0]    repeats_reg;
    logic                dir_reg;
    logic                yoyo_pend_reg;
    logic                finished_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [FRAME_BITS-1:0] table_mem [MAX_FRAMES];
    logic [FRAME_BITS-1:0] rd_data_reg;

    logic [Q_W-1:0]      cnt_eff;
    logic [PHASE_W-1:0]  full;
    logic [PHASE_W-1:0]  phase_sum;
    logic                wrap;
    logic                can_wrap;
    logic [Q_W-1:0]      pos;
    logic [Q_W-1:0]      idx;
    logic                wr_en;
    logic                rd_en;
    logic                mod_start;
    logic [Q_W-1:0]      mod_rem;
    mod_status_t         mod_st;
    logic                accept;
    logic                emit_ok;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign emit_ok    = !result_valid_reg || result_ready;

    // effective frame count, clamped to 1..MAX_FRAMES
    always_comb
    begin
        if (frame_count_reg == '0)
            cnt_eff = Q_W'(1);
        else if (32'(frame_count_reg) > MAX_FRAMES)
            cnt_eff = Q_W'(MAX_FRAMES);
        else
            cnt_eff = Q_W'(frame_count_reg);
    end

    assign full      = {cnt_eff, {PHASE_FRAC{1'b0}}};
    assign phase_sum = phase_reg + PHASE_W'(prod_reg[PROD_W-1:PROD_SHIFT]);
    assign wrap      = phase_sum >= full;
    assign can_wrap  = yoyo_pend_reg || (repeats_reg != '0);
    assign mod_start = (state_reg == S_ADD) && wrap && can_wrap;

    // position in pass and table address
    assign pos = (phase_reg >= full) ? cnt_eff - 1'b1 : phase_reg[PHASE_W-1:PHASE_FRAC];
    assign idx = dir_reg ? cnt_eff - 1'b1 - pos : pos;

    assign wr_en = (state_reg == S_EXEC) && (item_reg.kind == KIND_LOAD)
                   && (32'(item_reg.entry_index) < MAX_FRAMES);
    assign rd_en = (state_reg == S_READ);

    // serial remainder of the whole-frame part of the phase
    sfs_mod_unit #(
        .Q_W (Q_W)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .num    (phase_sum[PHASE_W-1:PHASE_FRAC]),
        .den    (cnt_eff),
        .rem    (mod_rem),
        .status (mod_st)
    );

    // frame table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[AW'(item_reg.entry_index)] <= FRAME_BITS'(item_reg.entry_value);
        if (rd_en)
            rd_data_reg <= table_mem[idx[AW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_EXEC;
            S_EXEC:
                if (item_reg.kind == KIND_TICK && !finished_reg)
                    state_next = S_ADD;
                else
                    state_next = S_READ;
            S_ADD:
                state_next = mod_start ? S_MOD : S_READ;
            S_MOD:
                if (mod_st.done)
                    state_next = S_READ;
            S_READ:
                state_next = S_RESP;
            S_RESP:
                if (emit_ok)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rate_reg   <= FRAME_RATE_RST;
            frame_count_reg  <= FRAME_COUNT_RST;
            repeat_count_reg <= '0;
            yoyo_enable_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_RATE:   frame_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_FRAME_COUNT:  frame_count_reg  <= cfg_data[FCNT_W-1:0];
                CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data[REP_W-1:0];
                CFG_YOYO_ENABLE:  yoyo_enable_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // playback state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= '0;
            repeats_reg      <= '0;
            dir_reg          <= 1'b0;
            yoyo_pend_reg    <= 1'b0;
            finished_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // result flag: set from the response state, cleared once taken
            if (state_reg == S_RESP && emit_ok)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                S_EXEC:
                    if (item_reg.kind == KIND_START)
                    begin
                        phase_reg     <= '0;
                        dir_reg       <= 1'b0;
                        repeats_reg   <= repeat_count_reg;
                        yoyo_pend_reg <= yoyo_enable_reg;
                        finished_reg  <= 1'b0;
                    end
                S_ADD:
                    if (!wrap)
                        phase_reg <= phase_sum;
                    else if (yoyo_pend_reg)
                    begin
                        yoyo_pend_reg <= 1'b0;
                        dir_reg       <= !dir_reg;
                    end
                    else if (repeats_reg != '0)
                    begin
                        // negative count loops forever
                        if (!repeats_reg[REP_W-1])
                            repeats_reg <= repeats_reg - 1'b1;
                        if (yoyo_enable_reg)
                            dir_reg <= !dir_reg;
                        yoyo_pend_reg <= yoyo_enable_reg;
                    end
                    else
                    begin
                        // out of repeats: park on the last frame
                        phase_reg    <= full;
                        finished_reg <= 1'b1;
                    end
                S_MOD:
                    if (mod_st.done)
                        phase_reg <= {mod_rem, phase_sum[PHASE_FRAC-1:0]};
                default:
                    ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (state_reg == S_EXEC)
            prod_reg <= PROD_W'(frame_rate_reg) * PROD_W'(item_reg.delta_time);
        if (state_reg == S_RESP && emit_ok)
        begin
            result_reg.frame_value <= VAL_W'(rd_data_reg);
            result_reg.position    <= pos[POS_W-1:0];
            result_reg.reversed    <= dir_reg;
            result_reg.done_res    <= finished_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // remainder unit runs only while the FSM waits on it
    a_mod_in_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_st.busy |-> (state_reg == S_MOD))
        else $error("modulo unit busy outside wrap state");

    // an accepted transaction goes straight to execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

    // a new result only comes from the response state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_RESP))
        else $error("result raised outside response state");

    // ticks after finished playback skip the phase add
    a_finished_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> !finished_reg)
        else $error("tick processed after playback finished");
`endif

endmodule

`default_nettype wire

### hw/rtl/sfs_mod_unit.sv
// Bit-serial remainder unit: num mod den, one quotient bit per cycle.
// Depends on sfs_pkg (mod_status_t).
`default_nettype none

module sfs_mod_unit
    import sfs_pkg::*;
#(
    parameter int Q_W = 9
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [Q_W-1:0] num,
    input  wire logic [Q_W-1:0] den,
    output logic [Q_W-1:0]      rem,
    output mod_status_t         status
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [Q_W-1:0]   num_reg;
    logic [Q_W-1:0]   den_reg;
    logic [Q_W-1:0]   rem_reg;
    logic [Q_W:0]     trial;
    logic             fits;

    // restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, num_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[Q_W-2:0], 1'b0};
            rem_reg <= fits ? Q_W'(trial - {1'b0, den_reg}) : trial[Q_W-1:0];
        end
    end

    assign rem         = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire
